>>> rtl/core/clf_pkg.sv
// Package: shared constants, codes and types of the CRLF line framer.
package clf_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int LIMIT_W     = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int USER_OUT_W  = 5;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef logic [LENGTH_BITS-1:0] t_len;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_LIMIT  = 2'd0,
        REG_REPLY_CHECK = 2'd1
    } t_reg_idx;

    typedef enum logic [1:0] {
        PH_BOL   = 2'd0,
        PH_FUZZY = 2'd1,
        PH_IN    = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_OVF = 2'd1,
        ST_EOS = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RK_NONE  = 2'd0,
        RK_CONT  = 2'd1,
        RK_FINAL = 2'd2,
        RK_BAD   = 2'd3
    } t_reply_kind;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        has_byte;
        logic        line_end;
        t_status     status;
        t_reply_kind reply_kind;
    } t_result;

endpackage

>>> rtl/core/crlf_line_framer_with_reply_check_core.sv
// Top level: CRLF line framer with optional three-digit reply check.
// Takes one byte per clock and gives at most one result per byte, in the cycle after the
// transfer; a new byte is taken every cycle while the output register is empty or being
// drained, so sustained rate is one byte per cycle. The per-byte state (phase, length
// counter, reply-check flags) is updated with each accepted byte. An LF directly after a
// CR or NUL line end produces no result. Overflow is sticky until reset. Configuration writes
// take effect at the next clock edge and must be made while the block is idle.
module crlf_line_framer_with_reply_check_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write port
    input  logic                          i_cfg_we,
    input  logic [clf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [clf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] in_byte
    input  logic                          s_axis_tuser,   // [0] end_of_stream
    // output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,   // [7:0] out_byte
    output logic                          m_axis_tlast,   // line_end
    output logic [clf_pkg::USER_OUT_W-1:0] m_axis_tuser   // [0] has_byte, [2:1] status,
                                                          // [4:3] reply_kind
);

    localparam clf_pkg::t_len LEN_MAX = '1;
    localparam clf_pkg::t_len LEN_3   = clf_pkg::LENGTH_BITS'(3);
    localparam int CMP_W = (clf_pkg::LENGTH_BITS > clf_pkg::LIMIT_W) ?
                           clf_pkg::LENGTH_BITS : clf_pkg::LIMIT_W;

    // config registers
    logic [clf_pkg::LIMIT_W-1:0] r_line_limit;
    logic                        r_reply_check;

    // line state
    clf_pkg::t_phase r_phase, n_phase;
    clf_pkg::t_len   r_len, n_len;
    logic            r_reply_bad, n_reply_bad;
    logic            r_reply_cont, n_reply_cont;
    logic            r_ovf, n_ovf;

    // output register
    logic             r_out_valid;
    clf_pkg::t_result r_out, n_out;
    logic             n_emit;

    logic        accept;
    logic [7:0]  c;
    logic        is_digit;
    logic        limit_hit;
    clf_pkg::t_reply_kind kind;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign c             = s_axis_tdata;
    assign is_digit      = (c >= clf_pkg::CH_ZERO) && (c <= clf_pkg::CH_NINE);
    assign limit_hit     = (r_line_limit != '0) &&
                           (CMP_W'(r_len) >= CMP_W'(r_line_limit));

    always_comb begin
        if (!r_reply_check) begin
            kind = clf_pkg::RK_NONE;
        end else if (r_reply_bad || r_len < LEN_3) begin
            kind = clf_pkg::RK_BAD;
        end else if (r_reply_cont) begin
            kind = clf_pkg::RK_CONT;
        end else begin
            kind = clf_pkg::RK_FINAL;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_len        = r_len;
        n_reply_bad  = r_reply_bad;
        n_reply_cont = r_reply_cont;
        n_ovf        = r_ovf;
        n_emit       = 1'b1;
        n_out        = '{out_byte: 8'h00, has_byte: 1'b0, line_end: 1'b0,
                         status: clf_pkg::ST_OK, reply_kind: clf_pkg::RK_NONE};
        if (s_axis_tuser) begin
            n_out.status = clf_pkg::ST_EOS;
        end else if (r_ovf) begin
            n_out.status = clf_pkg::ST_OVF;
        end else if (c == clf_pkg::CH_CR || c == clf_pkg::CH_NUL ||
                     c == clf_pkg::CH_LF) begin
            if (c == clf_pkg::CH_LF && r_phase == clf_pkg::PH_FUZZY) begin
                // LF after CR/NUL is swallowed
                n_emit = 1'b0;
            end else begin
                n_out.line_end   = 1'b1;
                n_out.reply_kind = kind;
                n_len            = '0;
                n_reply_bad      = 1'b0;
                n_reply_cont     = 1'b0;
            end
            n_phase = (c == clf_pkg::CH_LF) ? clf_pkg::PH_BOL : clf_pkg::PH_FUZZY;
        end else if (limit_hit) begin
            n_ovf        = 1'b1;
            n_out.status = clf_pkg::ST_OVF;
        end else begin
            n_phase = clf_pkg::PH_IN;
            if (r_len < LEN_3) begin
                if (!is_digit) begin
                    n_reply_bad = 1'b1;
                end
            end else if (r_len == LEN_3) begin
                if (c == clf_pkg::CH_DASH) begin
                    n_reply_cont = 1'b1;
                end else if (c != clf_pkg::CH_SPACE) begin
                    n_reply_bad = 1'b1;
                end
            end
            if (r_len != LEN_MAX) begin
                n_len = r_len + 1'b1;
            end
            n_out.out_byte = c;
            n_out.has_byte = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_limit  <= '0;
            r_reply_check <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                clf_pkg::REG_LINE_LIMIT:  r_line_limit  <= i_cfg_data[clf_pkg::LIMIT_W-1:0];
                clf_pkg::REG_REPLY_CHECK: r_reply_check <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= clf_pkg::PH_BOL;
            r_len        <= '0;
            r_reply_bad  <= 1'b0;
            r_reply_cont <= 1'b0;
            r_ovf        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_phase      <= n_phase;
                r_len        <= n_len;
                r_reply_bad  <= n_reply_bad;
                r_reply_cont <= n_reply_cont;
                r_ovf        <= n_ovf;
            end
            if (s_axis_tready) begin
                r_out_valid <= accept && n_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.out_byte;
    assign m_axis_tlast  = r_out.line_end;
    assign m_axis_tuser  = {r_out.reply_kind, r_out.status, r_out.has_byte};

endmodule

>>> rtl/core/clf_checker.sv
// Checker: port-level assertions for the CRLF line framer, bound to the top level.
module clf_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [7:0]                     m_axis_tdata,
    input logic                           m_axis_tlast,
    input logic [clf_pkg::USER_OUT_W-1:0] m_axis_tuser
);

    // output register empties on reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
        $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // a content byte is never a line end, error or checked reply
    a_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
        !m_axis_tlast && m_axis_tuser[4:1] == '0)
        else $error("content byte carries other fields");

    // line end, overflow or end-of-stream result carries no byte
    a_marker_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tlast || m_axis_tuser[2:1] != clf_pkg::ST_OK) |->
        !m_axis_tuser[0] && m_axis_tdata == 8'h00)
        else $error("marker result carries a byte");

    // full output register that is not drained blocks input
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input ready while result stalled");

endmodule

bind crlf_line_framer_with_reply_check_core clf_checker u_clf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

>>> tb/crlf_line_framer_with_reply_check_core_tb.sv
// Testbench for the CRLF line framer: directed table, random lines and a scoreboard.
module crlf_line_framer_with_reply_check_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PERIOD       = 10;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int IDLE_BOUND   = 1000;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_ITEMS  = 180;
    localparam int REPORT_MAX   = 10;

    // index with no register behind it; writes must be ignored
    localparam logic [clf_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef enum int {PACE_FULL, PACE_NONE, PACE_SPARSE} t_pace;

    typedef struct {
        bit                             is_cfg;
        logic [clf_pkg::CFG_IDX_W-1:0]  idx;
        logic [clf_pkg::CFG_DATA_W-1:0] val;
        logic [7:0]                     data;
        logic                           eos;
        bit                             fixed;
        clf_pkg::t_result               res;
    } t_dir_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [clf_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [clf_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata;   // [7:0] in_byte
    logic                            s_axis_tuser;   // [0] end_of_stream
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [7:0]                      m_axis_tdata;   // [7:0] out_byte
    logic                            m_axis_tlast;   // line_end
    logic [clf_pkg::USER_OUT_W-1:0]  m_axis_tuser;   // [0] has_byte, [2:1] status,
                                                     // [4:3] reply_kind

    // framer shadow state and registers
    logic [clf_pkg::LIMIT_W-1:0] sh_limit;
    logic                        sh_check;
    clf_pkg::t_phase             sh_phase;
    clf_pkg::t_len               sh_len;
    logic                        sh_bad;
    logic                        sh_cont;
    logic                        sh_ovf;

    clf_pkg::t_result pending_results[$];
    t_dir_row         directed[$];
    clf_pkg::t_result want;
    t_pace            pace = PACE_FULL;
    bit               avoid_ovf;
    int               produced;
    int               bad_results;
    int               lost_results;
    int               taken;
    int               taken_seen;
    int               rx_stall;
    int               cycles;

    crlf_line_framer_with_reply_check_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int draw_gap();
        case (pace)
            PACE_NONE:   return 0;
            PACE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 14) : 0;
            default:     return $urandom_range(0, 14);
        endcase
    endfunction

    function automatic clf_pkg::t_result mk_res(logic [7:0] b, logic hb, logic le,
                                                clf_pkg::t_status st,
                                                clf_pkg::t_reply_kind rk);
        return '{out_byte: b, has_byte: hb, line_end: le, status: st, reply_kind: rk};
    endfunction

    // Advance the shadow framer by one byte; returns 1 when a result is due.
    function automatic bit frame_byte(logic [7:0] b, logic eos, output clf_pkg::t_result r);
        clf_pkg::t_reply_kind kind;
        r = mk_res(8'h00, 1'b0, 1'b0, clf_pkg::ST_OK, clf_pkg::RK_NONE);
        if (eos) begin
            r.status = clf_pkg::ST_EOS;
            return 1;
        end
        if (sh_ovf) begin
            r.status = clf_pkg::ST_OVF;
            return 1;
        end
        if (b == clf_pkg::CH_CR || b == clf_pkg::CH_NUL || b == clf_pkg::CH_LF) begin
            if (b == clf_pkg::CH_LF && sh_phase == clf_pkg::PH_FUZZY) begin
                sh_phase = clf_pkg::PH_BOL;
                return 0;
            end
            sh_phase = (b == clf_pkg::CH_LF) ? clf_pkg::PH_BOL : clf_pkg::PH_FUZZY;
            kind = clf_pkg::RK_NONE;
            if (sh_check)
                kind = (sh_bad || sh_len < 3) ? clf_pkg::RK_BAD :
                       (sh_cont ? clf_pkg::RK_CONT : clf_pkg::RK_FINAL);
            sh_len  = '0;
            sh_bad  = 1'b0;
            sh_cont = 1'b0;
            r.line_end   = 1'b1;
            r.reply_kind = kind;
            return 1;
        end
        if (sh_limit != 0 && sh_len >= sh_limit) begin
            sh_ovf   = 1'b1;
            r.status = clf_pkg::ST_OVF;
            return 1;
        end
        sh_phase = clf_pkg::PH_IN;
        if (sh_len < 3) begin
            if (b < clf_pkg::CH_ZERO || b > clf_pkg::CH_NINE)
                sh_bad = 1'b1;
        end else if (sh_len == 3) begin
            if (b == clf_pkg::CH_DASH)
                sh_cont = 1'b1;
            else if (b != clf_pkg::CH_SPACE)
                sh_bad = 1'b1;
        end
        if (sh_len != '1)
            sh_len++;
        r.out_byte = b;
        r.has_byte = 1'b1;
        return 1;
    endfunction

    function automatic t_dir_row dir_byte(logic [7:0] b, logic eos);
        t_dir_row row;
        row = '{default: '0};
        row.data = b;
        row.eos  = eos;
        return row;
    endfunction

    function automatic t_dir_row dir_fixed(logic [7:0] b, logic eos, clf_pkg::t_result r);
        t_dir_row row;
        row = dir_byte(b, eos);
        row.fixed = 1'b1;
        row.res   = r;
        return row;
    endfunction

    function automatic t_dir_row dir_cfg(logic [clf_pkg::CFG_IDX_W-1:0] idx,
                                         logic [clf_pkg::CFG_DATA_W-1:0] val);
        t_dir_row row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.val    = val;
        return row;
    endfunction

    task automatic feed(input logic [7:0] b, input logic eos = 1'b0, input bit fixed = 1'b0,
                        input clf_pkg::t_result fres = '0);
        int               gap;
        bit               due;
        clf_pkg::t_result r;
        // keep random lines under the limit: overflow is sticky, so it is saved for the end
        if (avoid_ovf && !eos && sh_limit != 0 && sh_len >= sh_limit &&
            b != clf_pkg::CH_LF && b != clf_pkg::CH_NUL)
            b = clf_pkg::CH_CR;
        gap = draw_gap();
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= eos;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        due = frame_byte(b, eos, r);
        if (fixed) begin
            pending_results.push_back(fres);
            produced++;
        end else if (due) begin
            pending_results.push_back(r);
            produced++;
        end
    endtask

    task automatic wait_idle();
        int waited;
        waited = 0;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0 && waited < IDLE_BOUND) begin
            @(negedge i_clk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            $display("missing results: %0d", pending_results.size());
            lost_results += pending_results.size();
            pending_results.delete();
        end
        // a dropped LF may still be in flight
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_reg(input logic [clf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [clf_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            clf_pkg::REG_LINE_LIMIT:  sh_limit = val;
            clf_pkg::REG_REPLY_CHECK: sh_check = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_term();
        case ($urandom_range(0, 7))
            0, 1, 2, 3: begin
                feed(clf_pkg::CH_CR);
                feed(clf_pkg::CH_LF);
            end
            4: feed(clf_pkg::CH_LF);
            5: feed(clf_pkg::CH_CR);
            6: feed(clf_pkg::CH_NUL);
            default: begin
                feed(clf_pkg::CH_NUL);
                feed(clf_pkg::CH_LF);
            end
        endcase
    endtask

    task automatic send_line();
        int         n;
        int         pos;
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                repeat (3) feed(8'($urandom_range(clf_pkg::CH_ZERO, clf_pkg::CH_NINE)));
                case ($urandom_range(0, 2))
                    0: n = 0;
                    1: begin
                        feed(clf_pkg::CH_SPACE);
                        n = $urandom_range(0, 12);
                    end
                    default: begin
                        feed(clf_pkg::CH_DASH);
                        n = $urandom_range(0, 12);
                    end
                endcase
                repeat (n) feed(8'($urandom_range(8'h20, 8'h7E)));
                send_term();
            end
            6: begin
                repeat ($urandom_range(0, 6)) feed(8'($urandom_range(0, 255)));
                send_term();
            end
            7: begin
                // almost a reply: one digit just outside the range, or a random printable non-space separator
                pos = $urandom_range(0, 3);
                for (int k = 0; k < 4; k++) begin
                    if (k < 3)
                        c = (k == pos) ? (($urandom_range(0, 1) != 0) ? 8'h2F : 8'h3A)
                            : 8'($urandom_range(clf_pkg::CH_ZERO, clf_pkg::CH_NINE));
                    else
                        c = (pos == 3) ? 8'($urandom_range(8'h21, 8'h7E)) : clf_pkg::CH_SPACE;
                    feed(c);
                end
                send_term();
            end
            8: begin
                if ($urandom_range(0, 1) != 0)
                    feed(8'($urandom_range(0, 255)), 1'b1);
                else
                    send_term();
            end
            default: repeat ($urandom_range(1, 20)) feed(8'($urandom_range(0, 255)));
        endcase
    endtask

    // receiver: stall a random number of cycles before each result
    always @(negedge i_clk) begin
        if (taken != taken_seen) begin
            taken_seen = taken;
            rx_stall   = draw_gap();
        end
        if (rx_stall > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            taken++;
            if (pending_results.size() == 0) begin
                bad_results++;
                if (bad_results <= REPORT_MAX)
                    $display("unexpected transfer: byte=%h user=%b last=%b",
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.out_byte || m_axis_tuser[0] !== want.has_byte ||
                    m_axis_tlast !== want.line_end || m_axis_tuser[2:1] !== want.status ||
                    m_axis_tuser[4:3] !== want.reply_kind) begin
                    bad_results++;
                    if (bad_results <= REPORT_MAX)
                        $display("mismatch byte/hb/end/st/rk: exp %h %b %b %0d %0d, got %h %b %b %0d %0d",
                                 want.out_byte, want.has_byte, want.line_end, want.status,
                                 want.reply_kind, m_axis_tdata, m_axis_tuser[0],
                                 m_axis_tlast, m_axis_tuser[2:1], m_axis_tuser[4:3]);
                end
            end
        end
    end

    initial begin
        logic [clf_pkg::LIMIT_W-1:0] lim_v;
        logic                        chk_v;
        int                          target;
        logic [7:0]                  c;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        sh_limit      = '0;
        sh_check      = 1'b0;
        sh_phase      = clf_pkg::PH_BOL;
        sh_len        = '0;
        sh_bad        = 1'b0;
        sh_cont       = 1'b0;
        sh_ovf        = 1'b0;
        avoid_ovf     = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed.push_back(dir_cfg(REG_UNMAPPED, 16'hFFFF));
        directed.push_back(dir_fixed(8'hFF, 1'b1, mk_res(8'h00, 1'b0, 1'b0, clf_pkg::ST_EOS,
                                                         clf_pkg::RK_NONE)));
        directed.push_back(dir_fixed(clf_pkg::CH_NUL, 1'b0,
                                     mk_res(8'h00, 1'b0, 1'b1, clf_pkg::ST_OK,
                                            clf_pkg::RK_NONE)));
        directed.push_back(dir_byte(clf_pkg::CH_LF, 1'b0));
        directed.push_back(dir_fixed(8'hFF, 1'b0, mk_res(8'hFF, 1'b1, 1'b0, clf_pkg::ST_OK,
                                                         clf_pkg::RK_NONE)));
        directed.push_back(dir_fixed(clf_pkg::CH_LF, 1'b0,
                                     mk_res(8'h00, 1'b0, 1'b1, clf_pkg::ST_OK,
                                            clf_pkg::RK_NONE)));
        directed.push_back(dir_byte(clf_pkg::CH_LF, 1'b0));
        directed.push_back(dir_cfg(clf_pkg::REG_REPLY_CHECK, 16'h0001));
        directed.push_back(dir_byte("2", 1'b0));
        directed.push_back(dir_byte("5", 1'b0));
        directed.push_back(dir_byte("0", 1'b0));
        directed.push_back(dir_byte(clf_pkg::CH_DASH, 1'b0));
        directed.push_back(dir_byte("A", 1'b0));
        directed.push_back(dir_fixed(clf_pkg::CH_CR, 1'b1,
                                     mk_res(8'h00, 1'b0, 1'b0, clf_pkg::ST_EOS,
                                            clf_pkg::RK_NONE)));
        directed.push_back(dir_byte(clf_pkg::CH_CR, 1'b0));
        directed.push_back(dir_byte(clf_pkg::CH_LF, 1'b0));
        directed.push_back(dir_byte("0", 1'b0));
        directed.push_back(dir_byte("9", 1'b0));
        directed.push_back(dir_byte("9", 1'b0));
        directed.push_back(dir_byte(clf_pkg::CH_CR, 1'b0));
        directed.push_back(dir_byte("1", 1'b0));
        directed.push_back(dir_byte("2", 1'b0));
        directed.push_back(dir_byte(clf_pkg::CH_LF, 1'b0));
        directed.push_back(dir_byte("3", 1'b0));
        directed.push_back(dir_byte(":", 1'b0));
        directed.push_back(dir_byte("0", 1'b0));
        directed.push_back(dir_byte(clf_pkg::CH_SPACE, 1'b0));
        directed.push_back(dir_byte(clf_pkg::CH_NUL, 1'b0));

        foreach (directed[i]) begin
            if (directed[i].is_cfg) begin
                wait_idle();
                set_reg(directed[i].idx, directed[i].val);
            end else begin
                feed(directed[i].data, directed[i].eos, directed[i].fixed, directed[i].res);
            end
        end

        avoid_ovf = 1'b1;
        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            case (ph)
                0: begin lim_v = '0;     chk_v = 1'b1; end
                1: begin lim_v = '1;     chk_v = 1'b0; end
                2: begin lim_v = 16'd1;  chk_v = 1'b1; end
                3: begin lim_v = 16'd3;  chk_v = 1'b1; end
                4: begin lim_v = 16'd1024; chk_v = 1'b0; end
                5: begin
                    lim_v = 16'($urandom_range(4, 40));
                    chk_v = 1'($urandom_range(0, 1));
                end
                6: begin
                    lim_v = 16'($urandom_range(1, 65535));
                    chk_v = 1'b1;
                end
                default: begin
                    lim_v = 16'd2;
                    chk_v = 1'($urandom_range(0, 1));
                end
            endcase
            set_reg(clf_pkg::REG_LINE_LIMIT, lim_v);
            set_reg(clf_pkg::REG_REPLY_CHECK, 16'(chk_v));
            pace   = t_pace'(ph % 3);
            target = produced + PHASE_ITEMS;
            while (produced < target)
                send_line();
        end

        // a reply line runs past a short limit and trips the sticky overflow
        wait_idle();
        avoid_ovf = 1'b0;
        pace      = PACE_NONE;
        set_reg(clf_pkg::REG_LINE_LIMIT, 16'd6);
        set_reg(clf_pkg::REG_REPLY_CHECK, 16'h0001);
        feed("4");
        feed("2");
        feed("1");
        feed(clf_pkg::CH_DASH);
        repeat (6) begin
            c = 8'($urandom_range(1, 255));
            if (c == clf_pkg::CH_CR || c == clf_pkg::CH_LF)
                c = "A";
            feed(c);
        end
        pace = PACE_FULL;
        repeat (30)
            feed(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);

        wait_idle();
        if (bad_results == 0 && lost_results == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/clf_pkg.sv
rtl/core/crlf_line_framer_with_reply_check_core.sv
rtl/core/clf_checker.sv
tb/crlf_line_framer_with_reply_check_core_tb.sv
